FILE: design/ret_pkg.sv
// Package for the row edge tracker: field widths, defaults and beat types.
// No dependencies; used by every module in the design folder.
package ret_pkg;

  localparam int COL_W            = 8;
  localparam int ROW_W            = 7;
  localparam int DEF_IMAGE_WIDTH  = 160;
  localparam int DEF_IMAGE_HEIGHT = 120;
  localparam logic [COL_W-1:0] MARGIN_RESET = 8'd20;

  // One input beat: a single binary pixel and its frame start flag
  typedef struct packed {
    logic pixel;
    logic frame_start;
  } in_beat_t;

  // One result beat per image row
  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] left_edge;
    logic [COL_W-1:0] right_edge;
    logic [COL_W-1:0] road_width;
    logic             frame_last;
  } out_beat_t;

  // Running edge search state within one row
  typedef struct packed {
    logic [COL_W-1:0] running_left;
    logic [COL_W-1:0] running_right;
    logic             right_found;
  } scan_t;

endpackage

FILE: design/row_edge_tracker_core.sv
// Row edge tracker top level: pixel stream in, one edge result per row out.
// Depends on ret_pkg and ret_edge_step.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one binary pixel per
//   beat, rows from the nearest row up to row 0, each row left to right.
//   in_data.frame_start restarts counting at column 0 of the nearest row.
//   Result channel (out_valid / out_stall / out_data) gives one beat per row,
//   registered on the edge that accepts the row's last pixel, so it is valid in
//   the cycle after that pixel is taken. Pixels that end no row give no result.
//   Throughput is one pixel per cycle while in_stall is low: the whole update is
//   one short pass from the accepted beat into the state and result registers.
//   cfg_wr_en / cfg_wr_data write the search margin (reset 20); write it only
//   while no row is in flight.
//   Reset (synchronous, rst_n low) sets column 0 of the nearest row, previous
//   edges to 0 and the last column, and empties the result register.
//   When the receiver stalls a held result, in_stall rises in the same cycle
//   so no pixel that could finish a row is taken; a free or draining result
//   register lets a new pixel in on every cycle.
module row_edge_tracker_core #(
  parameter int IMAGE_WIDTH  = ret_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ret_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ret_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ret_pkg::out_beat_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [ret_pkg::COL_W-1:0]   cfg_wr_data
);
  import ret_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [COL_W-1:0] WIDTH_VAL = COL_W'(IMAGE_WIDTH);
  localparam logic [ROW_W-1:0] NEAR_ROW  = ROW_W'(IMAGE_HEIGHT - 1);

  logic [COL_W-1:0] margin_r;
  logic [COL_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] previous_left_r, previous_left_nxt;
  logic [COL_W-1:0] previous_right_r, previous_right_nxt;
  scan_t            scan_r, scan_nxt, scan_cur, scan_upd;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic             accept;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             row_end;
  logic [COL_W-1:0] left, right;

  // Hold the input only while a result is stuck at the output
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Position of this beat, frame start forces the nearest row
  assign col = in_data.frame_start ? '0 : column_count_r;
  assign row = in_data.frame_start ? NEAR_ROW : row_count_r;

  // Fresh search state at the start of each row
  always_comb begin
    scan_cur = scan_r;
    if (col == '0) begin
      scan_cur.running_left  = '0;
      scan_cur.running_right = LAST_COL;
      scan_cur.right_found   = 1'b0;
    end
  end

  ret_edge_step #(
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_edge_step (
    .scan_in    (scan_cur),
    .col        (col),
    .pixel      (in_data.pixel),
    .active     (row != NEAR_ROW),
    .prev_left  (previous_left_r),
    .prev_right (previous_right_r),
    .margin     (margin_r),
    .scan_out   (scan_upd)
  );

  // Row result on the last column
  assign row_end = (col >= LAST_COL);
  assign left    = (row == NEAR_ROW) ? '0 : scan_upd.running_left;
  assign right   = (row == NEAR_ROW) ? LAST_COL : scan_upd.running_right;

  always_comb begin
    column_count_nxt   = column_count_r;
    row_count_nxt      = row_count_r;
    previous_left_nxt  = previous_left_r;
    previous_right_nxt = previous_right_r;
    scan_nxt           = scan_r;
    out_valid_nxt      = out_valid_r & out_stall;
    out_data_nxt       = out_data_r;
    if (accept) begin
      scan_nxt = scan_upd;
      if (!row_end) begin
        column_count_nxt = col + COL_W'(1);
        row_count_nxt    = row;
      end else begin
        column_count_nxt        = '0;
        row_count_nxt           = (row == '0) ? NEAR_ROW : row - ROW_W'(1);
        previous_left_nxt       = left;
        previous_right_nxt      = right;
        out_valid_nxt           = 1'b1;
        out_data_nxt.row_index  = row;
        out_data_nxt.left_edge  = left;
        out_data_nxt.right_edge = right;
        out_data_nxt.road_width = (right > left) ? (right - left) : WIDTH_VAL;
        out_data_nxt.frame_last = (row == '0);
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r              <= MARGIN_RESET;
      column_count_r        <= '0;
      row_count_r           <= NEAR_ROW;
      previous_left_r       <= '0;
      previous_right_r      <= LAST_COL;
      scan_r.running_left   <= '0;
      scan_r.running_right  <= LAST_COL;
      scan_r.right_found    <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        margin_r <= cfg_wr_data;
      end
      column_count_r   <= column_count_nxt;
      row_count_r      <= row_count_nxt;
      previous_left_r  <= previous_left_nxt;
      previous_right_r <= previous_right_nxt;
      scan_r           <= scan_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/ret_edge_step.sv
// Edge search update for one pixel: windows from the previous row's edges.
// Depends on ret_pkg.
module ret_edge_step #(
  parameter int IMAGE_WIDTH = ret_pkg::DEF_IMAGE_WIDTH
) (
  input  ret_pkg::scan_t                 scan_in,
  input  logic [ret_pkg::COL_W-1:0]      col,
  input  logic                           pixel,
  input  logic                           active,
  input  logic [ret_pkg::COL_W-1:0]      prev_left,
  input  logic [ret_pkg::COL_W-1:0]      prev_right,
  input  logic [ret_pkg::COL_W-1:0]      margin,
  output ret_pkg::scan_t                 scan_out
);
  import ret_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMAGE_WIDTH - 1);

  logic [COL_W:0]   left_sum;
  logic [COL_W-1:0] left_start;
  logic [COL_W-1:0] right_start;

  // Search window bounds, saturating instead of wrapping
  assign left_sum    = {1'b0, prev_left} + {1'b0, margin};
  assign left_start  = (left_sum > {1'b0, LAST_COL}) ? LAST_COL : left_sum[COL_W-1:0];
  assign right_start = (prev_right >= margin) ? (prev_right - margin) : '0;

  // Highest black column in the left window, first black column in the right one
  always_comb begin
    scan_out = scan_in;
    if (active && !pixel) begin
      if (col != '0 && col <= left_start) begin
        scan_out.running_left = col;
      end
      if (!scan_in.right_found && col >= right_start) begin
        scan_out.running_right = col;
        scan_out.right_found   = 1'b1;
      end
    end
  end

endmodule

FILE: design/ret_checker.sv
// Port-level checks for row_edge_tracker_core, bound to the top level.
// Depends on ret_pkg and row_edge_tracker_core.
module ret_checker #(
  parameter int IMAGE_WIDTH  = ret_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ret_pkg::DEF_IMAGE_HEIGHT
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ret_pkg::out_beat_t out_data
);
  import ret_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [COL_W-1:0] WIDTH_VAL = COL_W'(IMAGE_WIDTH);
  localparam logic [ROW_W-1:0] NEAR_ROW  = ROW_W'(IMAGE_HEIGHT - 1);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Input is held back only while a result is waiting and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Road width agrees with the edges
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.right_edge > out_data.left_edge) ?
      (out_data.road_width == out_data.right_edge - out_data.left_edge) :
      (out_data.road_width == WIDTH_VAL)))
    else $error("road width does not match edges");

  // Nearest row carries the full-width edges
  a_near_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_index == NEAR_ROW |->
      out_data.left_edge == '0 && out_data.right_edge == LAST_COL)
    else $error("nearest row edges wrong");

  // Frame end marker only on row zero
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame_last == (out_data.row_index == '0))
    else $error("frame_last mismatch");

endmodule

bind row_edge_tracker_core ret_checker #(
  .IMAGE_WIDTH  (IMAGE_WIDTH),
  .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_ret_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/testbench.sv
// Self-checking testbench for row_edge_tracker_core: pixel beats in, one edge beat per row out.
// Depends on ret_pkg and the design folder; the expected rows come from a local edge tracker.
`timescale 1ns / 100ps

module testbench;
  import ret_pkg::*;

  localparam int IMG_W    = DEF_IMAGE_WIDTH;
  localparam int IMG_H    = DEF_IMAGE_HEIGHT;
  localparam int LAST_COL = IMG_W - 1;
  localparam int NEAR_ROW = IMG_H - 1;

  typedef enum int {PIX_ROW, PIX_CUT, SET_MARGIN} step_kind_e;

  // One directed step: black columns are 0..lo and hi..last
  typedef struct {
    step_kind_e kind;
    bit         fs;
    int         lo;
    int         hi;
    int         arg;
    bit         typed;
    out_beat_t  want;
  } plan_step_t;

  typedef struct {
    int        serial;
    out_beat_t want;
  } pinned_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [COL_W-1:0]     cfg_wr_data = '0;

  // Edge tracker state, mirrors the block
  logic [COL_W-1:0]     margin_now = MARGIN_RESET;
  int                   col_pos = 0;
  int                   row_pos = NEAR_ROW;
  int                   prev_left = 0;
  int                   prev_right = LAST_COL;
  int                   run_left = 0;
  int                   run_right = LAST_COL;
  bit                   right_hit = 1'b0;

  out_beat_t            edge_rows_q[$];
  pinned_row_t          typed_rows_q[$];
  int                   rows_sent = 0;
  int                   rows_done = 0;
  int                   bad_rows = 0;
  bit                   calm = 1'b0;
  int                   road_l = 20;
  int                   road_r = 140;

  // Directed rows; typed rows carry their expected beat
  plan_step_t plan [23] = '{
    '{PIX_ROW,    1'b1, LAST_COL, IMG_W, 0,  1'b1, '{7'd119, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{PIX_ROW,    1'b0, LAST_COL, IMG_W, 0,  1'b1, '{7'd118, 8'd20,  8'd139, 8'd119, 1'b0}},
    '{PIX_ROW,    1'b0, -1,       IMG_W, 0,  1'b1, '{7'd117, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{PIX_ROW,    1'b0, 10,       150,   0,  1'b1, '{7'd116, 8'd10,  8'd150, 8'd140, 1'b0}},
    '{PIX_ROW,    1'b0, 40,       100,   0,  1'b0, '0},
    '{PIX_CUT,    1'b0, -1,       IMG_W, 37, 1'b0, '0},
    '{PIX_ROW,    1'b1, 50,       60,    0,  1'b1, '{7'd119, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{SET_MARGIN, 1'b0, 0,        0,     255, 1'b0, '0},
    '{PIX_ROW,    1'b0, LAST_COL, IMG_W, 0,  1'b1, '{7'd118, 8'd159, 8'd0,   8'd160, 1'b0}},
    '{PIX_ROW,    1'b0, 0,        IMG_W, 0,  1'b1, '{7'd117, 8'd0,   8'd0,   8'd160, 1'b0}},
    '{PIX_ROW,    1'b0, -1,       159,   0,  1'b1, '{7'd116, 8'd159, 8'd159, 8'd160, 1'b0}},
    '{PIX_ROW,    1'b0, 5,        154,   0,  1'b0, '0},
    '{SET_MARGIN, 1'b0, 0,        0,     0,  1'b0, '0},
    '{PIX_ROW,    1'b1, -1,       IMG_W, 0,  1'b1, '{7'd119, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{PIX_ROW,    1'b0, LAST_COL, IMG_W, 0,  1'b1, '{7'd118, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{PIX_ROW,    1'b0, 30,       120,   0,  1'b0, '0},
    '{SET_MARGIN, 1'b0, 0,        0,     159, 1'b0, '0},
    '{PIX_ROW,    1'b0, LAST_COL, IMG_W, 0,  1'b1, '{7'd116, 8'd159, 8'd0,   8'd160, 1'b0}},
    '{PIX_CUT,    1'b0, LAST_COL, IMG_W, 159, 1'b0, '0},
    '{PIX_ROW,    1'b1, LAST_COL, IMG_W, 0,  1'b1, '{7'd119, 8'd0,   8'd159, 8'd159, 1'b0}},
    '{SET_MARGIN, 1'b0, 0,        0,     20, 1'b0, '0},
    '{PIX_ROW,    1'b0, 12,       140,   0,  1'b0, '0},
    '{PIX_ROW,    1'b0, 25,       130,   0,  1'b0, '0}
  };

  row_edge_tracker_core #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the edge tracker by one pixel; returns 1 when a row completes
  function automatic bit track_pixel(input in_beat_t px, output out_beat_t row_out);
    int lstart;
    int rstart;
    int lft;
    int rgt;
    row_out = '0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = NEAR_ROW;
    end
    if (col_pos == 0) begin
      run_left  = 0;
      run_right = LAST_COL;
      right_hit = 1'b0;
    end
    // nearest row pixels never move the edges
    if (row_pos != NEAR_ROW && px.pixel == 1'b0) begin
      lstart = prev_left + int'(margin_now);
      if (lstart > LAST_COL) lstart = LAST_COL;
      rstart = (prev_right >= int'(margin_now)) ? prev_right - int'(margin_now) : 0;
      if (col_pos >= 1 && col_pos <= lstart) run_left = col_pos;
      if (!right_hit && col_pos >= rstart) begin
        run_right = col_pos;
        right_hit = 1'b1;
      end
    end
    if (col_pos < LAST_COL) begin
      col_pos++;
      return 1'b0;
    end
    if (row_pos == NEAR_ROW) begin
      lft = 0;
      rgt = LAST_COL;
    end else begin
      lft = run_left;
      rgt = run_right;
    end
    row_out.row_index  = ROW_W'(row_pos);
    row_out.left_edge  = COL_W'(lft);
    row_out.right_edge = COL_W'(rgt);
    row_out.road_width = COL_W'((rgt > lft) ? rgt - lft : IMG_W);
    row_out.frame_last = (row_pos == 0);
    prev_left  = lft;
    prev_right = rgt;
    col_pos    = 0;
    row_pos    = (row_pos == 0) ? NEAR_ROW : row_pos - 1;
    return 1'b1;
  endfunction

  // Road between lo and hi is white, everything else black
  function automatic logic [IMG_W-1:0] span_line(input int lo, input int hi);
    logic [IMG_W-1:0] line_px;
    for (int c = 0; c < IMG_W; c++) line_px[c] = (c > lo && c < hi);
    return line_px;
  endfunction

  // Random row: mostly a drifting road with a little noise
  function automatic logic [IMG_W-1:0] make_line();
    logic [IMG_W-1:0] line_px;
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 65) begin
      road_l += int'($urandom_range(12)) - 6;
      road_r += int'($urandom_range(12)) - 6;
      if (road_l < -1) road_l = -1;
      if (road_l > LAST_COL) road_l = LAST_COL;
      if (road_r < 0) road_r = 0;
      if (road_r > IMG_W) road_r = IMG_W;
      line_px = span_line(road_l, road_r);
      for (int c = 0; c < IMG_W; c++)
        if ($urandom_range(49) == 0) line_px[c] = ~line_px[c];
    end else if (pick < 75) begin
      road_l  = int'($urandom_range(LAST_COL));
      road_r  = int'($urandom_range(LAST_COL));
      line_px = span_line(road_l, road_r);
    end else if (pick < 83) begin
      line_px = '1;
    end else if (pick < 88) begin
      line_px = '0;
    end else begin
      for (int c = 0; c < IMG_W; c++) line_px[c] = $urandom_range(1);
    end
    return line_px;
  endfunction

  // Send the first count pixels of a row; frame start goes on its first pixel
  task automatic send_line(input logic [IMG_W-1:0] line_px, input bit fs, input int count);
    in_beat_t px;
    for (int c = 0; c < count; c++) begin
      px.pixel       = line_px[c];
      px.frame_start = fs && (c == 0);
      while (!calm && $urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= px;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    if (count == IMG_W) rows_sent++;
  endtask

  // n_rows whole rows, then an optional partial row; frame start goes on the first row sent if fs_first
  task automatic send_frame(input int n_rows, input bit fs_first, input int cut);
    for (int r = 0; r < n_rows; r++) send_line(make_line(), fs_first && (r == 0), IMG_W);
    if (cut >= 0) send_line(make_line(), fs_first && (n_rows == 0), cut);
  endtask

  // Margin writes only with the pipe drained
  task automatic write_margin(input logic [COL_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (edge_rows_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    margin_now  = value;
  endtask

  // Receiver backpressure
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 30);

  // Check result beats, then predict from accepted pixel beats
  always @(posedge clk) begin : score
    out_beat_t   want;
    out_beat_t   made;
    pinned_row_t pinned;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (edge_rows_q.size() == 0) begin
          bad_rows++;
          if (bad_rows <= 10) $display("unexpected row beat: row %0d", out_data.row_index);
        end else begin
          want = edge_rows_q.pop_front();
          if (out_data.row_index !== want.row_index || out_data.left_edge !== want.left_edge ||
              out_data.right_edge !== want.right_edge ||
              out_data.road_width !== want.road_width ||
              out_data.frame_last !== want.frame_last) begin
            bad_rows++;
            if (bad_rows <= 10)
              $display("row beat mismatch: got row %0d left %0d right %0d width %0d last %0b",
                       out_data.row_index, out_data.left_edge, out_data.right_edge,
                       out_data.road_width, out_data.frame_last,
                       "; expected row %0d left %0d right %0d width %0d last %0b",
                       want.row_index, want.left_edge, want.right_edge,
                       want.road_width, want.frame_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (track_pixel(in_data, made)) begin
          if (typed_rows_q.size() != 0 && typed_rows_q[0].serial == rows_done) begin
            pinned = typed_rows_q.pop_front();
            made   = pinned.want;
          end
          rows_done++;
          edge_rows_q.push_back(made);
        end
      end
    end
  end

  // Stimulus
  initial begin
    pinned_row_t pinned;
    int          phase_margin [6];
    int          m;
    int          cut;
    phase_margin = '{7, 255, 0, 0, 159, 1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset margin and the extremes
    foreach (plan[i]) begin
      case (plan[i].kind)
        SET_MARGIN: write_margin(COL_W'(plan[i].arg));
        PIX_CUT: send_line(span_line(plan[i].lo, plan[i].hi), plan[i].fs, plan[i].arg);
        default: begin
          if (plan[i].typed) begin
            pinned.serial = rows_sent;
            pinned.want   = plan[i].want;
            typed_rows_q.push_back(pinned);
          end
          send_line(span_line(plan[i].lo, plan[i].hi), plan[i].fs, IMG_W);
        end
      endcase
    end

    // short frames over a sweep of margins; one phase runs with no idling
    for (int p = 0; p < 6; p++) begin
      m = (p == 3) ? int'($urandom_range(255)) : phase_margin[p];
      calm = (p == 4);
      write_margin(COL_W'(m));
      for (int f = 0; f < 3; f++) begin
        cut = (f < 2 && $urandom_range(2) == 0) ? int'($urandom_range(LAST_COL)) : -1;
        send_frame(int'($urandom_range(6)), 1'b1, cut);
      end
    end
    calm = 1'b0;

    // one whole frame, a wrap into the next frame without frame start, then two short frames
    write_margin(COL_W'($urandom_range(40, 8)));
    send_frame(IMG_H, 1'b1, -1);
    send_frame(4, 1'b0, -1);
    send_frame(2, 1'b1, 60);
    send_frame(3, 1'b1, -1);

    in_valid <= 1'b0;
    while (edge_rows_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (bad_rows == 0 && edge_rows_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
design/ret_pkg.sv
design/ret_edge_step.sv
design/row_edge_tracker_core.sv
design/ret_checker.sv
verif/testbench.sv
